@@ hw/rtl/comment_strip_position_track_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Comment strip position track unit: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef COMMENT_STRIP_POSITION_TRACK_UNIT_MACROS_SVH
`define COMMENT_STRIP_POSITION_TRACK_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CSPT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cspt assertion failed");

// next-cycle implication, off during reset
`define CSPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cspt assertion failed");

// same-cycle implication, checked during reset too
`define CSPT_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("cspt assertion failed");

`endif

@@ hw/rtl/cspt_pkg.sv @@
// ---------------------------------------------------------------------------
// Comment strip position track package
// Widths, character codes, item types and the position update function.
// ---------------------------------------------------------------------------
package cspt_pkg;

   localparam int LINE_BITS = 20;
   localparam int COL_BITS  = 16;
   localparam int TAB_BITS  = 4;
   localparam int RSP_DEPTH = 4;
   localparam int PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int CNT_BITS  = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;

   localparam logic [TAB_BITS-1:0]  TAB_RESET  = TAB_BITS'(4);
   localparam logic [COL_BITS-1:0]  COL_ORIGIN = '0;
   localparam logic [LINE_BITS-1:0] FIRST_LINE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
   localparam logic [COL_BITS-1:0]  COL_MAX    = '1;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0]  col;
   } pos_type;

   typedef struct packed {
      logic [7:0]           char_out;
      logic [LINE_BITS-1:0] line_out;
      logic [COL_BITS-1:0]  col_out;
      logic                 end_marker;
      logic                 unclosed_comment;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic         wr0;
      logic         wr1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic pos_type move_past(input logic [7:0] c, input pos_type p,
                                         input logic [TAB_BITS-1:0] tab);
      pos_type       r;
      logic [COL_BITS:0] sum;
      r   = p;
      sum = {1'b0, p.col} + (COL_BITS+1)'(tab);
      if (c == CH_NL) begin
         if (p.line != LINE_MAX) r.line = p.line + LINE_BITS'(1);
         r.col = COL_ORIGIN;
      end else if (c == CH_TAB) begin
         r.col = sum[COL_BITS] ? COL_MAX : sum[COL_BITS-1:0];
      end else if (p.col != COL_MAX) begin
         r.col = p.col + COL_BITS'(1);
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/cspt_if.sv @@
// ---------------------------------------------------------------------------
// Comment strip position track channels
// Request and response valid/ready channels with their payload.
// ---------------------------------------------------------------------------
interface cspt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_file;

   modport source(output valid, output byte_in, output end_of_file, input ready);
   modport sink(input valid, input byte_in, input end_of_file, output ready);
endinterface

interface cspt_rsp_if;
   import cspt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [7:0]           char_out;
   logic [LINE_BITS-1:0] line_out;
   logic [COL_BITS-1:0]  col_out;
   logic                 end_marker;
   logic                 unclosed_comment;
   logic                 last;

   modport source(output valid, output char_out, output line_out, output col_out,
                  output end_marker, output unclosed_comment, output last,
                  input ready);
   modport sink(input valid, input char_out, input line_out, input col_out,
                input end_marker, input unclosed_comment, input last,
                output ready);
endinterface

@@ hw/rtl/cspt_core.sv @@
// ---------------------------------------------------------------------------
// Comment strip position track core
// Mode, look-ahead and position state with the single-step update.
// ---------------------------------------------------------------------------
module cspt_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cspt_pkg::TAB_BITS-1:0] csr_wr_data,
   input  logic                          take,
   input  logic [7:0]                    byte_in,
   input  logic                          end_of_file,
   output cspt_pkg::push_type            push
);
   import cspt_pkg::*;

   logic [TAB_BITS-1:0] tab_ff;
   mode_type            mode_ff, mode_in;
   logic [7:0]          held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   logic                star_ff, star_in;
   pos_type             pos_ff, pos_in;

   pos_type pos_held;
   logic    in_normal;
   logic    opener;

   assign pos_held  = move_past(held_ff, pos_ff, tab_ff);
   assign in_normal = (mode_ff != MODE_LINE) && (mode_ff != MODE_BLOCK);
   assign opener    = held_valid_ff && (held_ff == CH_SLASH) &&
                      ((byte_in == CH_SLASH) || (byte_in == CH_STAR));

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff        <= TAB_RESET;
         mode_ff       <= MODE_NORMAL;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         star_ff       <= 1'b0;
         pos_ff        <= '{line: FIRST_LINE, col: COL_ORIGIN};
      end else begin
         if (csr_wr_en) tab_ff <= csr_wr_data;
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         star_ff       <= star_in;
         pos_ff        <= pos_in;
      end
   end

   // next state
   always_comb begin
      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      star_in       = star_ff;
      pos_in        = pos_ff;
      if (take) begin
         if (end_of_file) begin
            mode_in       = MODE_NORMAL;
            held_in       = '0;
            held_valid_in = 1'b0;
            star_in       = 1'b0;
            pos_in        = '{line: FIRST_LINE, col: COL_ORIGIN};
         end else begin
            case (mode_ff)
               MODE_LINE: begin
                  if (byte_in == CH_NL) begin
                     mode_in       = MODE_NORMAL;
                     held_in       = byte_in;
                     held_valid_in = 1'b1;
                  end else begin
                     pos_in = move_past(byte_in, pos_ff, tab_ff);
                  end
               end
               MODE_BLOCK: begin
                  pos_in = move_past(byte_in, pos_ff, tab_ff);
                  if (star_ff && (byte_in == CH_SLASH)) begin
                     mode_in = MODE_NORMAL;
                     star_in = 1'b0;
                  end else begin
                     star_in = (byte_in == CH_STAR);
                  end
               end
               default: begin
                  if (opener) begin
                     pos_in        = move_past(byte_in, pos_held, tab_ff);
                     held_in       = '0;
                     held_valid_in = 1'b0;
                     star_in       = 1'b0;
                     mode_in       = (byte_in == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                  end else begin
                     mode_in = MODE_NORMAL;
                     if (held_valid_ff) pos_in = pos_held;
                     held_in       = byte_in;
                     held_valid_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      push       = '0;
      push.item0 = '{char_out: held_ff, line_out: pos_ff.line, col_out: pos_ff.col,
                     end_marker: 1'b0, unclosed_comment: 1'b0, last: 1'b1};
      push.item1 = '{char_out: 8'h00, line_out: pos_held.line, col_out: pos_held.col,
                     end_marker: 1'b1, unclosed_comment: 1'b0, last: 1'b1};
      if (take) begin
         if (end_of_file) begin
            push.wr0 = 1'b1;
            if (in_normal && held_valid_ff) begin
               push.wr1              = 1'b1;
               push.item0.last       = 1'b0;
               push.item1.line_out   = pos_held.line;
               push.item1.col_out    = pos_held.col;
            end else begin
               push.item0 = '{char_out: 8'h00, line_out: pos_ff.line,
                              col_out: pos_ff.col, end_marker: 1'b1,
                              unclosed_comment: (mode_ff == MODE_BLOCK),
                              last: 1'b1};
            end
         end else if (in_normal && held_valid_ff && !opener) begin
            push.wr0 = 1'b1;
         end
      end
   end

endmodule

@@ hw/rtl/cspt_rsp_fifo.sv @@
// ---------------------------------------------------------------------------
// Comment strip position track response queue
// Four-entry queue taking up to two items per cycle, one out per cycle while rsp ready is high.
// ---------------------------------------------------------------------------
module cspt_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  cspt_pkg::push_type push,
   output logic               space_ok,
   cspt_rsp_if.source         rsp
);
   import cspt_pkg::*;

   rsp_item_type          entry_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;
   rsp_item_type          head;

   assign pop      = rsp.valid && rsp.ready;
   assign space_ok = (count_ff <= CNT_BITS'(RSP_DEPTH - 2));
   assign head     = entry_ff[rd_ptr_ff];

   assign rsp.valid            = (count_ff != '0);
   assign rsp.char_out         = head.char_out;
   assign rsp.line_out         = head.line_out;
   assign rsp.col_out          = head.col_out;
   assign rsp.end_marker       = head.end_marker;
   assign rsp.unclosed_comment = head.unclosed_comment;
   assign rsp.last             = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.wr0) + PTR_BITS'(push.wr1);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.wr0) + CNT_BITS'(push.wr1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.wr0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.wr1) entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.item1;
   end

endmodule

@@ hw/rtl/comment_strip_position_track_unit.sv @@
// Order: a character enters the response queue when the item after it is taken; the end marker
// enters with the end-of-file item, behind any character it flushes. Throughput: one item per
// cycle while the queue has room for two, set by the single-step core; an end-of-file item puts
// one or two results into the four-entry queue, which drains one per cycle while rsp is ready.
// Reset: synchronous, clears mode, look-ahead, position and queue; tab width returns to 4.
// ---------------------------------------------------------------------------
// Comment strip position track unit
// Strips C-style comments from a byte stream and tags survivors with line and column.
// ---------------------------------------------------------------------------
module comment_strip_position_track_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cspt_pkg::TAB_BITS-1:0] csr_wr_data,
   cspt_req_if.sink                      req_if,
   cspt_rsp_if.source                    rsp_if
);
   import cspt_pkg::*;

   push_type push;
   logic     space_ok;
   logic     take;

   assign req_if.ready = space_ok;
   assign take         = req_if.valid && space_ok;

   cspt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .byte_in     (req_if.byte_in),
      .end_of_file (req_if.end_of_file),
      .push        (push)
   );

   cspt_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_if)
   );

endmodule

@@ hw/rtl/cspt_checker.sv @@
// ---------------------------------------------------------------------------
// Comment strip position track port checker
// Port-level properties of the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "comment_strip_position_track_unit_macros.svh"

module cspt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [7:0]                     rsp_char_out,
   input logic [cspt_pkg::LINE_BITS-1:0] rsp_line_out,
   input logic [cspt_pkg::COL_BITS-1:0]  rsp_col_out,
   input logic                           rsp_end_marker,
   input logic                           rsp_unclosed_comment,
   input logic                           rsp_last
);
   import cspt_pkg::*;

   logic [$bits(rsp_item_type)-1:0] payload;
   logic                            stalled;
   logic                            end_seen;
   logic                            char_seen;

   assign payload   = {rsp_char_out, rsp_line_out, rsp_col_out, rsp_end_marker,
                       rsp_unclosed_comment, rsp_last};
   assign stalled   = rsp_valid && !rsp_ready;
   assign end_seen  = rsp_valid && rsp_end_marker;
   assign char_seen = rsp_valid && !rsp_end_marker;

   `CSPT_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(payload))
   `CSPT_ASSERT_IMPLY(a_end_is_last, clock, reset, end_seen, rsp_last && (rsp_char_out == 8'h00))
   `CSPT_ASSERT_IMPLY(a_char_no_unclosed, clock, reset, char_seen, !rsp_unclosed_comment)
   `CSPT_ASSERT_IMPLY(a_line_nonzero, clock, reset, rsp_valid, rsp_line_out != '0)
   `CSPT_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset), !rsp_valid)

endmodule

bind comment_strip_position_track_unit cspt_checker u_cspt_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_char_out         (rsp_if.char_out),
   .rsp_line_out         (rsp_if.line_out),
   .rsp_col_out          (rsp_if.col_out),
   .rsp_end_marker       (rsp_if.end_marker),
   .rsp_unclosed_comment (rsp_if.unclosed_comment),
   .rsp_last             (rsp_if.last)
);

@@ bench/comment_strip_position_track_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Comment strip position track unit test
// Feeds source text into the stripper and tracks each surviving character
// with its own copy of the mode, the look-ahead byte and the line and
// column counters. Checks every result field in order against that
// prediction. Covers comment openers and closers, end of file in each mode
// and tab widths from zero to fifteen. Ends with random source-like
// text phases under mostly bursty input and a sometimes stalling output.
// ---------------------------------------------------------------------------
module comment_strip_position_track_unit_test;
   import cspt_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 200;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_RUNS
   } ready_style_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [TAB_BITS-1:0] csr_wr_data;

   cspt_req_if byte_ch();
   cspt_rsp_if char_ch();

   comment_strip_position_track_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (byte_ch),
      .rsp_if      (char_ch)
   );

   // tracker state
   mode_type             text_mode;
   logic [7:0]           held_byte;
   logic                 held_ok;
   logic                 star_seen;
   logic [LINE_BITS-1:0] pos_line;
   logic [COL_BITS-1:0]  pos_col;
   logic [TAB_BITS-1:0]  tab_cols;

   rsp_item_type    surviving_q[$];
   int              mismatch_count;
   int              cycle_count;
   logic            bursty;
   int              burst_left;
   ready_style_type ready_style;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("comment_strip_position_track_unit_test: FAIL");
         $finish;
      end
   end

   function automatic void clear_text_state();
      text_mode = MODE_NORMAL;
      held_byte = 8'h00;
      held_ok   = 1'b0;
      star_seen = 1'b0;
      pos_line  = FIRST_LINE;
      pos_col   = COL_ORIGIN;
   endfunction

   function automatic void advance_position(input logic [7:0] c);
      int unsigned wide;
      if (c == CH_NL) begin
         if (pos_line != LINE_MAX) pos_line = pos_line + LINE_BITS'(1);
         pos_col = COL_ORIGIN;
      end else if (c == CH_TAB) begin
         wide    = 32'(pos_col) + 32'(tab_cols);
         pos_col = (wide > 32'(COL_MAX)) ? COL_MAX : wide[COL_BITS-1:0];
      end else if (pos_col != COL_MAX) begin
         pos_col = pos_col + COL_BITS'(1);
      end
   endfunction

   function automatic void expect_char(input logic [7:0] c, input logic eom,
                                       input logic open, input logic fin);
      rsp_item_type r;
      r.char_out         = c;
      r.line_out         = pos_line;
      r.col_out          = pos_col;
      r.end_marker       = eom;
      r.unclosed_comment = open;
      r.last             = fin;
      surviving_q.insert(surviving_q.size(), r);
   endfunction

   function automatic void strip_step(input logic [7:0] b, input logic eof);
      if (eof) begin
         if (text_mode != MODE_LINE && text_mode != MODE_BLOCK && held_ok) begin
            expect_char(held_byte, 1'b0, 1'b0, 1'b0);
            advance_position(held_byte);
         end
         expect_char(8'h00, 1'b1, text_mode == MODE_BLOCK, 1'b1);
         clear_text_state();
      end else if (text_mode == MODE_LINE) begin
         if (b == CH_NL) begin
            text_mode = MODE_NORMAL;
            held_byte = b;
            held_ok   = 1'b1;
         end else begin
            advance_position(b);
         end
      end else if (text_mode == MODE_BLOCK) begin
         advance_position(b);
         if (star_seen && b == CH_SLASH) begin
            text_mode = MODE_NORMAL;
            star_seen = 1'b0;
         end else begin
            star_seen = (b == CH_STAR);
         end
      end else if (held_ok && held_byte == CH_SLASH && (b == CH_SLASH || b == CH_STAR)) begin
         advance_position(held_byte);
         advance_position(b);
         held_ok   = 1'b0;
         held_byte = 8'h00;
         star_seen = 1'b0;
         text_mode = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
      end else begin
         text_mode = MODE_NORMAL;
         if (held_ok) begin
            expect_char(held_byte, 1'b0, 1'b0, 1'b1);
            advance_position(held_byte);
         end
         held_byte = b;
         held_ok   = 1'b1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && char_ch.valid && char_ch.ready) begin
         if (surviving_q.size() == 0) begin
            $display("%0t: char_out expected none actual %0h", $time, char_ch.char_out);
            mismatch_count++;
         end else begin
            want = surviving_q.pop_front();
            check_field("char_out", want.char_out, char_ch.char_out);
            check_field("line_out", want.line_out, char_ch.line_out);
            check_field("col_out", want.col_out, char_ch.col_out);
            check_field("end_marker", want.end_marker, char_ch.end_marker);
            check_field("unclosed_comment", want.unclosed_comment,
                        char_ch.unclosed_comment);
            check_field("last", want.last, char_ch.last);
         end
      end
   end

   initial begin : drive_ready
      int   run;
      logic level;
      char_ch.ready <= 1'b0;
      run   = 0;
      level = 1'b1;
      forever begin
         @(posedge clock);
         case (ready_style)
            READY_ALWAYS: char_ch.ready <= 1'b1;
            READY_COIN:   char_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (run == 0) begin
                  run   = $urandom_range(1, 8);
                  level = ~level;
               end
               run--;
               char_ch.ready <= level;
            end
         endcase
      end
   end

   task automatic put_item(input logic [7:0] b, input logic eof);
      int gap;
      if (bursty && burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      byte_ch.valid       <= 1'b1;
      byte_ch.byte_in     <= b;
      byte_ch.end_of_file <= eof;
      @(posedge clock);
      while (!byte_ch.ready) @(posedge clock);
      strip_step(b, eof);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
   endtask

   task automatic put_eof();
      put_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic settle();
      byte_ch.valid <= 1'b0;
      do @(posedge clock); while (surviving_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tab_cols(input logic [TAB_BITS-1:0] w);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      tab_cols = w;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 8'($urandom_range(8'h61, 8'h7A));
      if (pick < 55) return CH_NL;
      if (pick < 63) return CH_TAB;
      if (pick < 71) return CH_SLASH;
      if (pick < 79) return CH_STAR;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic put_random_token(inout int sent);
      int         pick;
      int         n;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         put_item(pick_byte(), 1'b0);
         sent++;
      end else if (pick < 60) begin
         n = $urandom_range(0, 10);
         put_text("//");
         for (int i = 0; i < n; i++) begin
            c = pick_byte();
            put_item((c == CH_NL) ? 8'h63 : c, 1'b0);
         end
         put_item(CH_NL, 1'b0);
         sent += n + 3;
      end else if (pick < 75) begin
         n = $urandom_range(0, 10);
         put_text("/*");
         for (int i = 0; i < n; i++) put_item(pick_byte(), 1'b0);
         put_text("*/");
         sent += n + 4;
      end else if (pick < 80) begin
         put_text("/*/");
         sent += 3;
      end else if (pick < 86) begin
         put_item(CH_SLASH, 1'b0);
         put_item(pick_byte(), 1'b0);
         sent += 2;
      end else if (pick < 97) begin
         put_item(8'($urandom_range(0, 255)), 1'b0);
         sent++;
      end else begin
         put_eof();
         sent++;
      end
   endtask

   task automatic test_plain_and_line_comment();
      put_text("a\t/b//x/*\n");
      put_item(8'h00, 1'b0);
      put_item(8'hFF, 1'b0);
      put_item(CH_SLASH, 1'b0);
      put_eof();
   endtask

   task automatic test_nested_openers();
      put_text("/*/ *//*a/**/q");
      put_eof();
      put_text("//z");
      put_eof();
      put_text("/*z*");
      put_eof();
      put_eof();
   endtask

   task automatic test_tab_widths();
      logic [TAB_BITS-1:0] widths[3] = '{4'd0, 4'd1, 4'd15};
      foreach (widths[i]) begin
         write_tab_cols(widths[i]);
         put_text("\t\tk\t");
         put_eof();
      end
   endtask

   task automatic test_random_text();
      logic [TAB_BITS-1:0] widths[7];
      int                  sent;
      widths = '{4'd15, 4'd0, 4'd1, TAB_BITS'($urandom_range(0, 15)),
                 TAB_BITS'($urandom_range(0, 15)), TAB_RESET, 4'd7};
      foreach (widths[i]) begin
         write_tab_cols(widths[i]);
         ready_style = ready_style_type'($urandom_range(0, 2));
         bursty      = ($urandom_range(0, 4) != 0);
         sent        = 0;
         while (sent < PHASE_ITEMS) put_random_token(sent);
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= TAB_RESET;
      byte_ch.valid       <= 1'b0;
      byte_ch.byte_in     <= 8'h00;
      byte_ch.end_of_file <= 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      bursty         = 1'b1;
      burst_left     = 0;
      ready_style    = READY_COIN;
      tab_cols       = TAB_RESET;
      clear_text_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_plain_and_line_comment();
      test_nested_openers();
      test_tab_widths();
      test_random_text();

      settle();
      if (mismatch_count == 0) begin
         $display("comment_strip_position_track_unit_test: PASS");
      end else begin
         $display("comment_strip_position_track_unit_test: FAIL");
      end
      $finish;
   end

endmodule
